FILE: hw/rtl/cst_pkg.sv
package cst_pkg;

	localparam int KEY_W  = 32;
	localparam int CNT_W  = 16;
	localparam int WORD_W = KEY_W + CNT_W;

	localparam logic [1:0] FN_CREATE = 2'd0;
	localparam logic [1:0] FN_FREE   = 2'd1;
	localparam logic [1:0] FN_WAIT   = 2'd2;
	localparam logic [1:0] FN_SIGNAL = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_BLOCK     = 3'd3;
	localparam logic [2:0] ST_SAT       = 3'd4;

	localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;

	typedef struct packed {
		logic [1:0]              func;
		logic signed [KEY_W-1:0] sem_id;
		logic signed [CNT_W-1:0] init_value;
	} cst_req_t;

	typedef struct packed {
		logic [2:0]              status;
		logic signed [CNT_W-1:0] count_after;
	} cst_res_t;

	// table update strobes from the sequencer
	typedef struct packed {
		logic we;
		logic vld_set;
		logic vld_clr;
	} cst_ctl_t;

endpackage

FILE: hw/rtl/counting_semaphore_table_unit.sv
// Transactions are not overlapped: a new start is taken only in the idle state, after the
// previous result. The serial key scan reads one table entry per cycle through the single
// RAM read port, then one operation step follows and the unit returns to idle before the
// next start is taken.
// The result strobe is high for one cycle; the receiver cannot stall it.
// Reset clears the valid bits at once; keys and counts are not cleared.
module counting_semaphore_table_unit import cst_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  cst_req_t req,
	output logic     busy,
	output logic     done,
	output cst_res_t result
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [ENTRIES-1:0] valid_q;
	logic               rd_vld_q;
	logic [IW-1:0]      rd_addr;
	logic [WORD_W-1:0]  rd_data;
	logic [IW-1:0]      wr_addr;
	logic [WORD_W-1:0]  wr_data;
	cst_ctl_t           ctl;

	cst_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ctl.we),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// valid bits registered on read, in step with the RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[rd_addr];
			if (ctl.vld_set) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (ctl.vld_clr) begin
				valid_q[wr_addr] <= 1'b0;
			end
		end
	end

	cst_seq #(
		.ENTRIES(ENTRIES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.rd_vld (rd_vld_q),
		.ctl    (ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.done   (done),
		.result (result)
	);

endmodule

FILE: hw/rtl/cst_ram.sv
module cst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/cst_seq.sv
module cst_seq import cst_pkg::*; #(
	parameter int ENTRIES = 16,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cst_req_t          req,
	output logic              busy,
	output logic [IW-1:0]     rd_addr,
	input  logic [WORD_W-1:0] rd_data,
	input  logic              rd_vld,
	output cst_ctl_t          ctl,
	output logic [IW-1:0]     wr_addr,
	output logic [WORD_W-1:0] wr_data,
	output logic              done,
	output cst_res_t          result
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	logic [1:0]              state_q;
	logic [IW-1:0]           idx_q;
	logic                    issue_done_q;
	logic                    chk_s1;
	logic [IW-1:0]           chk_idx_s1;
	logic                    found_q;
	logic [IW-1:0]           slot_q;
	logic signed [CNT_W-1:0] cnt_q;
	logic                    free_found_q;
	logic [IW-1:0]           free_slot_q;
	cst_req_t                req_q;
	logic                    done_q;
	cst_res_t                res_q;

	logic [KEY_W-1:0]        rd_key;
	logic signed [CNT_W-1:0] rd_cnt;
	logic                    hit;
	cst_res_t                res_d;

	assign rd_key  = rd_data[WORD_W-1:CNT_W];
	assign rd_cnt  = rd_data[CNT_W-1:0];
	assign hit     = chk_s1 && rd_vld && (rd_key == req_q.sem_id);
	assign rd_addr = idx_q;
	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign result  = res_q;

	// operation step, in the cycle after the scan has drained
	always_comb begin
		ctl       = '0;
		wr_addr   = slot_q;
		wr_data   = {req_q.sem_id, cnt_q};
		res_d     = '{status: ST_OK, count_after: '0};
		if (state_q == S_EXEC) begin
			if (req_q.func == FN_CREATE) begin
				if (found_q) begin
					res_d.count_after = cnt_q;
				end else if (free_found_q) begin
					ctl.we            = 1'b1;
					ctl.vld_set       = 1'b1;
					wr_addr           = free_slot_q;
					wr_data           = {req_q.sem_id, req_q.init_value};
					res_d.count_after = req_q.init_value;
				end else begin
					res_d.status = ST_FULL;
				end
			end else if (!found_q) begin
				res_d.status = ST_NOT_FOUND;
			end else begin
				case (req_q.func)
					FN_FREE: begin
						ctl.vld_clr = 1'b1;
					end
					FN_WAIT: begin
						if (cnt_q <= 16'sd0) begin
							res_d.status      = ST_BLOCK;
							res_d.count_after = cnt_q;
						end else begin
							ctl.we            = 1'b1;
							wr_data           = {req_q.sem_id, cnt_q - 16'sd1};
							res_d.count_after = cnt_q - 16'sd1;
						end
					end
					default: begin
						if (cnt_q == CNT_MAX) begin
							res_d.status      = ST_SAT;
							res_d.count_after = cnt_q;
						end else begin
							ctl.we            = 1'b1;
							wr_data           = {req_q.sem_id, cnt_q + 16'sd1};
							res_d.count_after = cnt_q + 16'sd1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			chk_s1       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q      <= S_SCAN;
						idx_q        <= '0;
						issue_done_q <= 1'b0;
						chk_s1       <= 1'b0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					// read issue runs one entry ahead of the compare
					chk_s1 <= !issue_done_q;
					if (!issue_done_q) begin
						if (idx_q == LAST) begin
							issue_done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (hit && !found_q) begin
						found_q <= 1'b1;
					end
					if (chk_s1 && !rd_vld && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (chk_s1 && chk_idx_s1 == LAST) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
		chk_idx_s1 <= idx_q;
		if (hit && !found_q) begin
			slot_q <= chk_idx_s1;
			cnt_q  <= rd_cnt;
		end
		if (state_q == S_SCAN && chk_s1 && !rd_vld && !free_found_q) begin
			free_slot_q <= chk_idx_s1;
		end
		if (state_q == S_EXEC) begin
			res_q <= res_d;
		end
	end

	a_wr_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.we || ctl.vld_clr) |-> (state_q == S_EXEC))
		else $error("table update outside the operation step");

	a_set_writes: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.vld_set |-> (ctl.we && req_q.func == FN_CREATE && !found_q))
		else $error("valid set without a create write");

	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (done_q && state_q == S_IDLE))
		else $error("operation step did not deliver a result");

	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_SCAN && idx_q == '0 && !found_q))
		else $error("accepted transaction did not start a scan");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

endmodule

FILE: verif/tb.sv
module tb;
	import cst_pkg::*;

	localparam int ENTRIES    = 16;
	localparam int IDLE_LIMIT = 2000;
	localparam int RAND_ITEMS = 1800;
	localparam int PHASE_LEN  = 200;

	typedef struct {
		cst_req_t req;
		bit       typed;
		cst_res_t want;
	} dir_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	cst_req_t req = '0;
	logic     busy;
	logic     done;
	cst_res_t result;

	// shadow copy of the semaphore table
	logic                    sem_valid [ENTRIES];
	logic [KEY_W-1:0]        sem_key   [ENTRIES];
	logic signed [CNT_W-1:0] sem_cnt   [ENTRIES];

	cst_res_t   pending_res[$];
	dir_row_t   dir_rows[$];
	logic [31:0] key_pool[32];
	int          pool_n;
	int          txn_count = 0;
	int          dir_count = 0;
	int          res_count = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          stat_count[5] = '{default: 0};

	counting_semaphore_table_unit #(.ENTRIES(ENTRIES)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #6 clk = ~clk;

	// applies one request to the shadow table and returns its result
	function automatic cst_res_t sem_apply(cst_req_t r);
		int hit;
		int slot;
		cst_res_t o;
		o.status = ST_OK;
		o.count_after = '0;
		hit = -1;
		slot = -1;
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (sem_valid[i] && sem_key[i] == r.sem_id)
				hit = i;
		if (r.func == FN_CREATE) begin
			if (hit >= 0) begin
				o.count_after = sem_cnt[hit];
			end else begin
				for (int i = ENTRIES - 1; i >= 0; i--)
					if (!sem_valid[i])
						slot = i;
				if (slot < 0) begin
					o.status = ST_FULL;
				end else begin
					sem_valid[slot] = 1'b1;
					sem_key[slot] = r.sem_id;
					sem_cnt[slot] = r.init_value;
					o.count_after = r.init_value;
				end
			end
		end else if (hit < 0) begin
			o.status = ST_NOT_FOUND;
		end else begin
			case (r.func)
				FN_FREE: begin
					sem_valid[hit] = 1'b0;
				end
				FN_WAIT: begin
					if (sem_cnt[hit] <= 0)
						o.status = ST_BLOCK;
					else
						sem_cnt[hit] = sem_cnt[hit] - 16'sd1;
					o.count_after = sem_cnt[hit];
				end
				default: begin
					if (sem_cnt[hit] == CNT_MAX)
						o.status = ST_SAT;
					else
						sem_cnt[hit] = sem_cnt[hit] + 16'sd1;
					o.count_after = sem_cnt[hit];
				end
			endcase
		end
		return o;
	endfunction

	function automatic int pick_gap(bit quiet);
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 5);
		return $urandom_range(10, 150);
	endfunction

	function automatic void add_row(logic [1:0] f, logic [31:0] id, logic [15:0] init,
			bit typed, logic [2:0] st, logic [15:0] cnt);
		dir_row_t row;
		row.req.func = f;
		row.req.sem_id = id;
		row.req.init_value = init;
		row.typed = typed;
		row.want.status = st;
		row.want.count_after = cnt;
		dir_rows.push_back(row);
	endfunction

	// drives one transaction after an idle gap; the expectation is queued at the
	// accepting edge
	task automatic issue(input cst_req_t r, input bit typed, input cst_res_t want,
			input int gap);
		cst_res_t pred;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		pred = sem_apply(r);
		pending_res.push_back(typed ? want : pred);
		txn_count++;
	endtask

	task automatic drain_table(input bit quiet);
		cst_req_t r;
		for (int i = 0; i < ENTRIES; i++) begin
			if (sem_valid[i]) begin
				r.func = FN_FREE;
				r.sem_id = sem_key[i];
				r.init_value = 16'($urandom);
				issue(r, 1'b0, '0, pick_gap(quiet));
			end
		end
	endtask

	always @(posedge clk) begin
		cst_res_t want;
		if (arst_n && done) begin
			res_count++;
			if (result.status < 5)
				stat_count[result.status]++;
			if (pending_res.size() == 0) begin
				$error("unexpected result: status %0d count_after %0d",
					result.status, result.count_after);
				mismatches++;
			end else begin
				want = pending_res.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					mismatches++;
				end
				if (result.count_after !== want.count_after) begin
					$error("count_after: expected %0d, got %0d",
						want.count_after, result.count_after);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		cst_req_t r;
		cst_res_t full_res;
		int roll;
		int k;
		bit quiet;

		for (int i = 0; i < ENTRIES; i++) begin
			sem_valid[i] = 1'b0;
			sem_key[i] = '0;
			sem_cnt[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table first, then the count extremes and the identifier extremes
		add_row(FN_WAIT,   32'd5,         16'd0,      1'b1, ST_NOT_FOUND, 16'd0);
		add_row(FN_SIGNAL, 32'd5,         16'd0,      1'b1, ST_NOT_FOUND, 16'd0);
		add_row(FN_FREE,   32'd5,         16'd0,      1'b1, ST_NOT_FOUND, 16'd0);
		add_row(FN_CREATE, 32'h7FFF_FFFF, 16'h7FFF,   1'b1, ST_OK,        16'h7FFF);
		add_row(FN_SIGNAL, 32'h7FFF_FFFF, 16'd0,      1'b1, ST_SAT,       16'h7FFF);
		add_row(FN_WAIT,   32'h7FFF_FFFF, 16'hFFFF,   1'b0, ST_OK,        16'd0);
		add_row(FN_CREATE, 32'h8000_0000, 16'h8000,   1'b1, ST_OK,        16'h8000);
		add_row(FN_WAIT,   32'h8000_0000, 16'd0,      1'b1, ST_BLOCK,     16'h8000);
		add_row(FN_SIGNAL, 32'h8000_0000, 16'd0,      1'b0, ST_OK,        16'd0);
		add_row(FN_CREATE, 32'd0,         16'd0,      1'b1, ST_OK,        16'd0);
		add_row(FN_WAIT,   32'd0,         16'd0,      1'b1, ST_BLOCK,     16'd0);
		add_row(FN_CREATE, 32'd0,         16'h5555,   1'b1, ST_OK,        16'd0);
		add_row(FN_FREE,   32'd0,         16'd0,      1'b1, ST_OK,        16'd0);
		add_row(FN_FREE,   32'd0,         16'd0,      1'b1, ST_NOT_FOUND, 16'd0);
		add_row(FN_CREATE, 32'hFFFF_FFFF, 16'd1,      1'b0, ST_OK,        16'd0);
		add_row(FN_WAIT,   32'hFFFF_FFFF, 16'd0,      1'b0, ST_OK,        16'd0);
		add_row(FN_WAIT,   32'hFFFF_FFFF, 16'd0,      1'b1, ST_BLOCK,     16'd0);
		add_row(FN_SIGNAL, 32'hFFFF_FFFF, 16'hAAAA,   1'b0, ST_OK,        16'd0);
		foreach (dir_rows[i])
			issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want, pick_gap(1'b0));

		// fill every free slot, then one more create must report full
		k = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!sem_valid[i]) begin
				r.func = FN_CREATE;
				r.sem_id = 32'h5A5A_0000 ^ k;
				r.init_value = 16'(k);
				issue(r, 1'b0, '0, pick_gap(1'b0));
				k++;
			end
		end
		r.func = FN_CREATE;
		r.sem_id = 32'h1234_5678;
		r.init_value = 16'h7FFF;
		full_res.status = ST_FULL;
		full_res.count_after = '0;
		issue(r, 1'b1, full_res, pick_gap(1'b0));
		drain_table(1'b0);
		dir_count = txn_count;

		// random phases over key pools of varying size: small pools keep
		// hitting existing entries, pools above the table size fill it up
		for (int phase = 0; phase < RAND_ITEMS / PHASE_LEN; phase++) begin
			quiet = (phase % 4 == 3);
			case (phase % 5)
				0: pool_n = 3;
				1: pool_n = 8;
				2: pool_n = 16;
				3: pool_n = 20;
				default: pool_n = 28;
			endcase
			for (int i = 0; i < 32; i++)
				key_pool[i] = $urandom;
			if ($urandom_range(0, 2) == 0) begin
				key_pool[0] = 32'h0000_0000;
				key_pool[1] = 32'hFFFF_FFFF;
				key_pool[2] = 32'h7FFF_FFFF;
				key_pool[3] = 32'h8000_0000;
			end
			if ($urandom_range(0, 1) == 0)
				drain_table(quiet);
			for (int n = 0; n < PHASE_LEN; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 25)
					r.func = FN_CREATE;
				else if (roll < 40)
					r.func = FN_FREE;
				else if (roll < 70)
					r.func = FN_WAIT;
				else
					r.func = FN_SIGNAL;
				if ($urandom_range(0, 99) < 8)
					r.sem_id = $urandom;
				else
					r.sem_id = key_pool[$urandom_range(0, pool_n - 1)];
				case ($urandom_range(0, 9))
					0: r.init_value = 16'h7FFF;
					1: r.init_value = 16'h7FFE;
					2: r.init_value = 16'h8000;
					3: r.init_value = 16'h0000;
					4: r.init_value = 16'h0001;
					5: r.init_value = 16'hFFFF;
					default: r.init_value = 16'($urandom);
				endcase
				issue(r, 1'b0, '0, pick_gap(quiet));
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (ENTRIES + 13) @(posedge clk);

		$display("%0d transactions (%0d directed), %0d results checked",
			txn_count, dir_count, res_count);
		$display("status mix: ok %0d, not found %0d, full %0d, block %0d, saturated %0d",
			stat_count[ST_OK], stat_count[ST_NOT_FOUND], stat_count[ST_FULL],
			stat_count[ST_BLOCK], stat_count[ST_SAT]);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
